[rtl/min_tracking_stack_defines.svh]
// Assertion macros used by the checker file.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define MTS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define MTS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mts_pkg.sv]
`default_nettype none

package mts_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic              push;        // store the input value
    logic              pop;         // drop the top, using the read data
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              load_out;    // capture the result in the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/min_tracking_stack.sv]
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_op, in_push_value
// out       output     out_valid/out_ready  out_min_value, out_min_valid,
//                                           out_status, out_occupancy
// cfg       input      cfg_we (no wait)     cfg_wdata (capacity)
//
// A push or a rejected operation passes S_FIN on its way to the next in_ready;
// an accepted pop also passes S_RD, because the top value and the entry below
// the top of the minimum stack come out of the registered-read RAMs in the cycle
// after the transfer. The current minimum lives in a register, so a push needs
// no RAM read. Synchronous reset empties both stacks and sets capacity to 16;
// the stores are not cleared. A result waiting on out_ready does not block the
// next transfer in; only its own finished result waits for the output register.
`default_nettype none

module min_tracking_stack import mts_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [CAP_W-1:0]         cfg_wdata,
  // operation in
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_op,
  input  wire logic signed [DATA_W-1:0] in_push_value,
  // result out
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_min_value,
  output logic                          out_min_valid,
  output logic [STAT_W-1:0]             out_status,
  output logic [OCC_W-1:0]              out_occupancy
);

  cmd_t cmd;
  sts_t sts;

  // sequence each operation: accept, optional RAM read, hand off result
  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold both stacks, the counts, the cached minimum and the output register
  mts_dp #(.DEPTH(DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .push_value    (in_push_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_min_value (out_min_value),
    .out_min_valid (out_min_valid),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

endmodule

`default_nettype wire

[rtl/mts_ram.sv]
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/mts_ctrl.sv]
`default_nettype none

module mts_ctrl import mts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_op,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DONE;
          state_nxt      = S_FIN;
          if (in_op == OP_PUSH) begin
            if (sts.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (sts.empty) begin
            cmd.status = ST_EMPTY;
          end else begin
            // wait for the top entries to come out of the RAMs
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.pop   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/mts_dp.sv]
`default_nettype none

module mts_dp import mts_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CAP_W-1:0]         cfg_wdata,
  input  wire logic signed [DATA_W-1:0] push_value,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_min_value,
  output logic                          out_min_valid,
  output logic [STAT_W-1:0]             out_status,
  output logic [OCC_W-1:0]              out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]         cap_r;
  logic [CW-1:0]            vc_r, vc_nxt;
  logic [CW-1:0]            mc_r, mc_nxt;
  logic signed [DATA_W-1:0] min_top_r, min_top_nxt;
  logic [STAT_W-1:0]        status_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_min_value_r;
  logic                     out_min_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic [OCC_W-1:0]         out_occupancy_r;

  logic [LW-1:0]            limit;
  logic                     to_min;
  logic                     min_ok;
  logic signed [DATA_W-1:0] val_rdata;
  logic signed [DATA_W-1:0] min_rdata;

  assign limit  = (LW'(cap_r) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_r);
  assign to_min = (mc_r == '0) || (push_value <= min_top_r);
  assign min_ok = (vc_r != '0) && (mc_r != '0);

  assign sts.full     = LW'(vc_r) >= limit;
  assign sts.empty    = (vc_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (AW'(vc_r)),
    .wdata (push_value),
    .raddr (AW'(vc_r - CW'(1))),
    .rdata (val_rdata)
  );

  // read one below the top so the next minimum is ready when the top goes
  mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_min_ram (
    .clk   (clk),
    .we    (cmd.push && to_min),
    .waddr (AW'(mc_r)),
    .wdata (push_value),
    .raddr (AW'(mc_r - CW'(2))),
    .rdata (min_rdata)
  );

  always_comb begin
    vc_nxt      = vc_r;
    mc_nxt      = mc_r;
    min_top_nxt = min_top_r;
    if (cmd.push) begin
      vc_nxt = vc_r + CW'(1);
      if (to_min) begin
        mc_nxt      = mc_r + CW'(1);
        min_top_nxt = push_value;
      end
    end else if (cmd.pop) begin
      vc_nxt = vc_r - CW'(1);
      if (val_rdata == min_top_r) begin
        mc_nxt      = mc_r - CW'(1);
        min_top_nxt = min_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      vc_r        <= '0;
      mc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      vc_r <= vc_nxt;
      mc_r <= mc_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    min_top_r <= min_top_nxt;
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.load_out) begin
      out_min_value_r <= min_ok ? min_top_r : '0;
      out_min_valid_r <= min_ok;
      out_status_r    <= status_r;
      out_occupancy_r <= OCC_W'(LW'(vc_r));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_value_r;
  assign out_min_valid = out_min_valid_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

endmodule

`default_nettype wire

[rtl/mts_chk.sv]
`default_nettype none
`include "min_tracking_stack_defines.svh"

module mts_chk import mts_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DATA_W-1:0] out_min_value,
  input wire logic                     out_min_valid,
  input wire logic [STAT_W-1:0]        out_status,
  input wire logic [OCC_W-1:0]         out_occupancy
);

  // one operation at a time: no transfer right after a transfer
  `MTS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "in_ready high right after a transfer")

  // an empty stack reports a zero minimum and zero occupancy
  `MTS_ASSERT_IMP(a_empty_result, clk, rst_n, out_valid && !out_min_valid, (out_min_value == '0) && (out_occupancy == '0), "empty result with nonzero fields")

  // a rejected pop only happens on an empty stack
  `MTS_ASSERT_IMP(a_pop_reject, clk, rst_n, out_valid && (out_status == ST_EMPTY), !out_min_valid && (out_occupancy == '0), "pop rejected on a nonempty stack")

  // a stalled result holds
  `MTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_min_value) && $stable(out_status) && $stable(out_occupancy), "stalled result changed")

endmodule

bind min_tracking_stack mts_chk u_mts_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_min_value (out_min_value),
  .out_min_valid (out_min_valid),
  .out_status    (out_status),
  .out_occupancy (out_occupancy)
);

`default_nettype wire

[bench/min_tracking_stack_tb.sv]
`timescale 1ns / 1ps

module min_tracking_stack_tb;
  import mts_pkg::*;

  localparam int STACK_DEPTH  = 16;
  localparam int IDLE_PCT     = 31;      // share of cycles each side sits idle
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int SETTLE       = 6;       // quiet cycles after the last result
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 16;
  localparam int SCRIPT_LEN   = 24;

  // One result as the block reports it.
  typedef struct packed {
    logic signed [DATA_W-1:0] min_value;
    logic                     min_valid;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;
  } min_report_t;

  localparam min_report_t NO_REPORT = '0;

  typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

  // Directed row: an operation, or a capacity write carried in value.
  // typed rows carry the expected result as written; the rest use the predictor.
  typedef struct packed {
    row_kind_t                kind;
    logic                     op;
    logic signed [DATA_W-1:0] value;
    logic                     typed;
    min_report_t              want;
  } script_row_t;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  script_row_t script_rows [SCRIPT_LEN] = '{
    // pop from an empty stack right after reset
    '{ROW_OP, OP_POP,  32'sd0,  1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
    // extremes, and an equal value that must land on the minimum stack too
    '{ROW_OP, OP_PUSH, S32_MAX, 1'b1, '{S32_MAX, 1'b1, ST_DONE, 5'd1}},
    '{ROW_OP, OP_PUSH, S32_MIN, 1'b1, '{S32_MIN, 1'b1, ST_DONE, 5'd2}},
    '{ROW_OP, OP_PUSH, S32_MIN, 1'b1, '{S32_MIN, 1'b1, ST_DONE, 5'd3}},
    '{ROW_OP, OP_PUSH, 32'sd0,  1'b0, NO_REPORT},
    '{ROW_OP, OP_POP,  32'sd0,  1'b0, NO_REPORT},
    '{ROW_OP, OP_POP,  32'sd0,  1'b0, NO_REPORT},
    '{ROW_OP, OP_POP,  32'sd0,  1'b0, NO_REPORT},
    '{ROW_OP, OP_POP,  32'sd0,  1'b1, '{32'sd0, 1'b0, ST_DONE, 5'd0}},
    // capacity one: second push is rejected as full
    '{ROW_CAP, OP_PUSH, 32'sd1, 1'b0, NO_REPORT},
    '{ROW_OP, OP_PUSH, -32'sd1, 1'b1, '{-32'sd1, 1'b1, ST_DONE, 5'd1}},
    '{ROW_OP, OP_PUSH, 32'sd5,  1'b1, '{-32'sd1, 1'b1, ST_FULL, 5'd1}},
    // capacity zero, already below the occupancy: held value stays
    '{ROW_CAP, OP_PUSH, 32'sd0, 1'b0, NO_REPORT},
    '{ROW_OP, OP_PUSH, 32'sd7,  1'b1, '{-32'sd1, 1'b1, ST_FULL, 5'd1}},
    '{ROW_OP, OP_POP,  32'sd0,  1'b1, '{32'sd0, 1'b0, ST_DONE, 5'd0}},
    '{ROW_OP, OP_POP,  32'sd0,  1'b1, '{32'sd0, 1'b0, ST_EMPTY, 5'd0}},
    '{ROW_OP, OP_PUSH, 32'sd3,  1'b1, '{32'sd0, 1'b0, ST_FULL, 5'd0}},
    // capacity above the built depth saturates
    '{ROW_CAP, OP_PUSH, 32'sd31, 1'b0, NO_REPORT},
    '{ROW_OP, OP_PUSH, 32'sh5555_5555, 1'b0, NO_REPORT},
    '{ROW_OP, OP_PUSH, 32'shAAAA_AAAA, 1'b0, NO_REPORT},
    '{ROW_OP, OP_PUSH, 32'shAAAA_AAAA, 1'b0, NO_REPORT},
    '{ROW_OP, OP_POP,  32'sd0,  1'b0, NO_REPORT},
    '{ROW_OP, OP_POP,  32'sd0,  1'b0, NO_REPORT},
    '{ROW_CAP, OP_PUSH, 32'sd16, 1'b0, NO_REPORT}
  };

  // Capacity per random phase: extremes, saturation, and a spread in between.
  int unsigned phase_caps [PHASES] = '{16, 31, 1, 0, 2, 16, 20, 3,
                                       16, 8, 15, 0, 5, 24, 16, 9};

  // DUT ports; every input starts at a known value.
  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     cfg_we        = 1'b0;
  logic [CAP_W-1:0]         cfg_wdata     = '0;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic                     in_op         = OP_PUSH;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic signed [DATA_W-1:0] out_min_value;
  logic                     out_min_valid;
  logic [STAT_W-1:0]        out_status;
  logic [OCC_W-1:0]         out_occupancy;

  // Predictor state: value stack, stack of running minima, capacity register.
  logic signed [DATA_W-1:0] value_stack [STACK_DEPTH];
  logic signed [DATA_W-1:0] floor_stack [STACK_DEPTH];
  int unsigned              value_cnt = 0;
  int unsigned              floor_cnt = 0;
  logic [CAP_W-1:0]         cap_reg   = CAP_RESET;

  min_report_t min_reports [$];   // results still owed by the block
  min_report_t report_head;

  int  mismatches   = 0;
  int  cycle_cnt    = 0;
  int  push_cnt     = 0;
  int  pop_cnt      = 0;
  int  full_cnt     = 0;
  int  empty_cnt    = 0;
  int  cap_writes   = 0;
  int  peak_occ     = 0;
  bit  calm         = 1'b0;   // no idling on either side while set
  int  hold_asks    = 0;      // raised by the sender to request a hold-off
  int  hold_served  = 0;
  int  hold_left    = 0;

  min_tracking_stack #(.DEPTH(STACK_DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_min_value (out_min_value),
    .out_min_valid (out_min_valid),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one operation to the predictor and return the result it owes.
  function automatic min_report_t track_min_op(input logic op,
                                               input logic signed [DATA_W-1:0] v);
    min_report_t              r;
    int unsigned              room;
    logic signed [DATA_W-1:0] top;
    r.status = ST_DONE;
    // capacity above the built depth saturates; zero means always full
    room = (cap_reg > STACK_DEPTH) ? STACK_DEPTH : cap_reg;
    if (op == OP_PUSH) begin
      if (value_cnt >= room) begin
        r.status = ST_FULL;
      end else begin
        // a new minimum, or a tie with the current one, also goes on the floor stack
        if (floor_cnt == 0 || value_cnt == 0 || v <= floor_stack[floor_cnt-1]) begin
          if (floor_cnt < STACK_DEPTH) begin
            floor_stack[floor_cnt] = v;
            floor_cnt++;
          end
        end
        value_stack[value_cnt] = v;
        value_cnt++;
      end
    end else begin
      if (value_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        top = value_stack[value_cnt-1];
        value_cnt--;
        // drop the minimum only when the departing value is that minimum
        if (floor_cnt > 0 && floor_stack[floor_cnt-1] == top)
          floor_cnt--;
      end
    end
    if (value_cnt > 0 && floor_cnt > 0) begin
      r.min_value = floor_stack[floor_cnt-1];
      r.min_valid = 1'b1;
    end else begin
      r.min_value = '0;
      r.min_valid = 1'b0;
    end
    r.occupancy = value_cnt[OCC_W-1:0];
    return r;
  endfunction

  // Offer one operation, hold it until the transfer, then record its result.
  task automatic send_op(input logic op, input logic signed [DATA_W-1:0] value,
                         input logic typed, input min_report_t typed_report);
    min_report_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
    predicted = track_min_op(op, value);
    min_reports.insert(min_reports.size(), typed ? typed_report : predicted);
    if (op == OP_PUSH) push_cnt++;
    else pop_cnt++;
    if (predicted.status == ST_FULL) full_cnt++;
    if (predicted.status == ST_EMPTY) empty_cnt++;
    if (value_cnt > peak_occ) peak_occ = value_cnt;
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (min_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the capacity register, only with the block idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_reg = cap;
    cap_writes++;
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random stalls, a long hold-off on request, none while calm.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result transfer with the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (min_reports.size() == 0) begin
        $error("result with nothing owed: min %0d valid %0d status %0d occupancy %0d",
               out_min_value, out_min_valid, out_status, out_occupancy);
        mismatches++;
      end else begin
        report_head = min_reports.pop_front();
        check_field("min_value", report_head.min_value, out_min_value);
        check_field("min_valid", report_head.min_valid, out_min_valid);
        check_field("status", report_head.status, out_status);
        check_field("occupancy", report_head.occupancy, out_occupancy);
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_cnt, min_reports.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int                       items;
    int                       push_pct;
    logic                     op;
    logic signed [DATA_W-1:0] value;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table.
    foreach (script_rows[i]) begin
      if (script_rows[i].kind == ROW_CAP)
        set_capacity(script_rows[i].value[CAP_W-1:0]);
      else
        send_op(script_rows[i].op, script_rows[i].value, script_rows[i].typed,
                script_rows[i].want);
    end

    // Random part: the stack is not emptied between phases, so a lower capacity
    // often lands below the current occupancy.
    for (int ph = 0; ph < PHASES; ph++) begin
      set_capacity(phase_caps[ph][CAP_W-1:0]);
      calm  = (ph == 6);
      items = (phase_caps[ph] == 0) ? 40 : 110;
      // hold the receiver off while the sender keeps offering, so the block stalls with a result waiting
      if (ph == 9) hold_asks <= hold_asks + 1;
      push_pct = 50;
      for (int k = 0; k < items; k++) begin
        // swing between filling, draining and an even mix to reach full and empty
        if (k % 24 == 0) begin
          case ($urandom_range(2))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
          endcase
        end
        // pause the sender once mid-phase until all results are back
        if (ph == 11 && k == 20) drain_results();
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        // small values force ties with the minimum; extremes and full range too
        case ($urandom_range(19))
          0:                   value = S32_MIN;
          1:                   value = S32_MAX;
          2:                   value = -32'sd1;
          3, 4, 5, 6, 7, 8, 9: value = $signed($urandom_range(8)) - 32'sd4;
          default:             value = $signed($urandom);
        endcase
        send_op(op, value, 1'b0, NO_REPORT);
      end
    end

    calm = 1'b0;
    drain_results();

    $display("covered %0d pushes and %0d pops over %0d capacity writes, peak occupancy %0d",
             push_cnt, pop_cnt, cap_writes, peak_occ);
    $display("rejected %0d pushes as full and %0d pops as empty, %0d mismatches",
             full_cnt, empty_cnt, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[min_tracking_stack.f]
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/mts_ctrl.sv
rtl/mts_dp.sv
rtl/min_tracking_stack.sv
rtl/mts_chk.sv
bench/min_tracking_stack_tb.sv
